// ===== hdl/tlfc_pkg.sv =====
// Shared types and constants of the text line field counter.
`default_nettype none

package tlfc_pkg;

    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned FIELD_COUNT_W = 16;
    localparam int unsigned LINE_INDEX_W = 24;
    localparam int unsigned STATUS_W     = 2;
    localparam int unsigned CFG_INDEX_W  = 3;
    localparam int unsigned CFG_DATA_W   = 16;

    localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'd10;
    localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'd32;
    localparam logic [BYTE_W-1:0] CHAR_TAB     = 8'd9;
    localparam logic [BYTE_W-1:0] CHAR_CR      = 8'd13;

    localparam logic [STATUS_W-1:0] ST_LINE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FINAL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY_END = 2'd2;
    localparam logic [STATUS_W-1:0] ST_QUOTE_ERR = 2'd3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SEPARATOR  = 3'd0,
        CFG_QUOTE_A    = 3'd1,
        CFG_QUOTE_B    = 3'd2,
        CFG_SKIP_BLANK = 3'd3,
        CFG_SKIP_LINES = 3'd4
    } t_cfg_index;

    typedef enum logic [2:0] {
        PH_SKIP    = 3'd0,
        PH_LINE    = 3'd1,
        PH_TOKEN   = 3'd2,
        PH_WSQUOTE = 3'd3,
        PH_DONE    = 3'd4
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_input;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_COUNT_W-1:0] field_count;
        logic [LINE_INDEX_W-1:0]  line_index;
        logic [STATUS_W-1:0]      status;
        logic                     last;
    } t_out_item;

    typedef struct packed {
        logic [BYTE_W-1:0] separator;
        logic [BYTE_W-1:0] quote_a;
        logic [BYTE_W-1:0] quote_b;
        logic              skip_blank;
    } t_cfg;

    // A byte after classification, as it travels from the front to the back.
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              eoi;
        logic              is_newline;
        logic              is_space;
        logic              is_quote;
        logic              is_sep;
        logic              ws_mode;
    } t_class;

endpackage

`default_nettype wire

// ===== hdl/text_line_field_counter.sv =====
// Top level of the text line field counter: configuration registers and wiring.
//
// The block takes a text stream one byte per request on the input channel
// (i_in_valid / o_in_ready / i_in_data) and returns one result per reported
// line on the output channel (o_out_valid / i_out_ready / o_out_data). A
// request with end_of_input set closes the stream and yields the result
// marked last; after it every request is taken and dropped until reset.
// Throughput is one byte per cycle while the receiver takes the results. A
// byte is written into the two-entry classification queue at the edge that
// accepts it; the line state machine processes it once it is at the queue
// head and the result register is empty or being read, and that edge also
// loads the result register that drives o_out_valid. A stalled receiver holds the result register;
// the queue then fills, and o_in_ready falls once both entries are held.
// Reset is synchronous and active low: the configuration takes its default
// values (whitespace mode, double and single quote, blank lines skipped,
// no leading lines skipped) and the queue and result register empty.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data in
// one cycle and must only change while the block is idle.
`default_nettype none

module text_line_field_counter #(
    parameter int unsigned COUNT_WIDTH = 16,
    parameter int unsigned LINE_WIDTH  = 24
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [tlfc_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [tlfc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire tlfc_pkg::t_in_item                i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output tlfc_pkg::t_out_item                    o_out_data
);
    import tlfc_pkg::*;

    t_cfg   r_cfg;
    logic   w_skip_load;
    logic   w_head_valid;
    t_class w_head;
    logic   w_pop;

    // Register writes. The skip count has no copy here: a write loads the
    // back end's counter of lines still to skip directly.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.separator  <= '0;
            r_cfg.quote_a    <= 8'd34;
            r_cfg.quote_b    <= 8'd39;
            r_cfg.skip_blank <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SEPARATOR:  r_cfg.separator  <= i_cfg_data[BYTE_W-1:0];
                CFG_QUOTE_A:    r_cfg.quote_a    <= i_cfg_data[BYTE_W-1:0];
                CFG_QUOTE_B:    r_cfg.quote_b    <= i_cfg_data[BYTE_W-1:0];
                CFG_SKIP_BLANK: r_cfg.skip_blank <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign w_skip_load = i_cfg_we && (i_cfg_index == CFG_SKIP_LINES);

    tlfc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .o_head_valid (w_head_valid),
        .o_head       (w_head),
        .i_pop        (w_pop)
    );

    tlfc_back #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .LINE_WIDTH  (LINE_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_skip_blank (r_cfg.skip_blank),
        .i_skip_load  (w_skip_load),
        .i_skip_value (i_cfg_data),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule

`default_nettype wire

// ===== hdl/tlfc_front.sv =====
// Front end: classifies incoming bytes and holds them in a two-entry queue.
`default_nettype none

module tlfc_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tlfc_pkg::t_cfg    i_cfg,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire tlfc_pkg::t_in_item i_in_data,
    output logic                   o_head_valid,
    output tlfc_pkg::t_class       o_head,
    input  wire logic              i_pop
);
    import tlfc_pkg::*;

    t_class     w_class;
    t_class     r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_pop;
    logic [BYTE_W-1:0] w_c;

    assign w_c = i_in_data.data_byte;

    always_comb begin
        w_class.data_byte  = w_c;
        w_class.eoi        = i_in_data.end_of_input;
        w_class.is_newline = (w_c == CHAR_NEWLINE);
        w_class.is_space   = (w_c == CHAR_SPACE) || ((w_c >= CHAR_TAB) && (w_c <= CHAR_CR));
        w_class.is_quote   = (w_c != '0) && ((w_c == i_cfg.quote_a) || (w_c == i_cfg.quote_b));
        w_class.is_sep     = (w_c == i_cfg.separator);
        w_class.ws_mode    = (i_cfg.separator == '0);
    end

    assign o_in_ready   = (r_count != 2'd2);
    assign w_push       = i_in_valid && o_in_ready;
    assign o_head_valid = (r_count != 2'd0);
    assign w_pop        = i_pop && o_head_valid;
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_class;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/tlfc_back.sv =====
// Back end: the line and field state machine and the result register.
`default_nettype none

module tlfc_back #(
    parameter int unsigned COUNT_WIDTH = 16,
    parameter int unsigned LINE_WIDTH  = 24
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_skip_blank,
    input  wire logic                                 i_skip_load,
    input  wire logic [tlfc_pkg::CFG_DATA_W-1:0]      i_skip_value,
    input  wire logic                                 i_head_valid,
    input  wire tlfc_pkg::t_class                     i_head,
    output logic                                      o_pop,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output tlfc_pkg::t_out_item                       o_out_data
);
    import tlfc_pkg::*;

    t_phase                   r_phase, n_phase;
    logic [COUNT_WIDTH-1:0]   r_fields, n_fields;
    logic [BYTE_W-1:0]        r_quote, n_quote;
    logic [CFG_DATA_W-1:0]    r_to_skip, n_to_skip;
    logic [LINE_WIDTH-1:0]    r_line, n_line;
    logic                     r_out_valid, n_out_valid;
    t_out_item                r_out, n_out;

    t_phase                   w_eff;
    logic                     w_go;
    logic                     w_emit;
    logic [COUNT_WIDTH-1:0]   w_count;
    logic [STATUS_W-1:0]      w_status;
    logic                     w_last;
    logic [COUNT_WIDTH-1:0]   w_f;
    logic [BYTE_W-1:0]        w_q;
    logic [CFG_DATA_W-1:0]    w_skip_dec;

    assign o_pop       = i_head_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_phase    = r_phase;
        n_fields   = r_fields;
        n_quote    = r_quote;
        n_to_skip  = r_to_skip;
        n_line     = r_line;
        w_eff      = r_phase;
        w_go       = 1'b0;
        w_emit     = 1'b0;
        w_count    = '0;
        w_status   = ST_LINE;
        w_last     = 1'b0;
        w_f        = r_fields;
        w_q        = r_quote;
        w_skip_dec = r_to_skip - CFG_DATA_W'(1);

        if (o_pop && (r_phase != PH_DONE)) begin
            w_go = 1'b1;
            if (r_phase == PH_SKIP) begin
                if (i_head.eoi) begin
                    n_phase  = PH_DONE;
                    w_emit   = 1'b1;
                    w_status = ST_EMPTY_END;
                    w_last   = 1'b1;
                    w_go     = 1'b0;
                end else if (r_to_skip != '0) begin
                    if (i_head.is_newline) begin
                        n_to_skip = w_skip_dec;
                        if (w_skip_dec == '0) begin
                            n_phase = PH_LINE;
                        end
                    end
                    w_go = 1'b0;
                end else begin
                    w_eff   = PH_LINE;
                    n_phase = PH_LINE;
                end
            end

            if (w_go) begin
                if (i_head.eoi) begin
                    n_phase = PH_DONE;
                    w_emit  = 1'b1;
                    w_last  = 1'b1;
                    if (i_head.ws_mode && (w_eff == PH_WSQUOTE)) begin
                        w_status = ST_QUOTE_ERR;
                    end else if (r_fields != '0) begin
                        w_status = ST_FINAL;
                        w_count  = r_fields;
                    end else begin
                        w_status = ST_EMPTY_END;
                    end
                end else if (i_head.is_newline) begin
                    if (i_head.ws_mode && (w_eff == PH_WSQUOTE)) begin
                        n_phase  = PH_DONE;
                        w_emit   = 1'b1;
                        w_status = ST_QUOTE_ERR;
                        w_last   = 1'b1;
                    end else begin
                        n_phase = PH_LINE;
                        if ((r_fields != '0) || !i_skip_blank) begin
                            w_emit   = 1'b1;
                            w_count  = r_fields;
                            w_status = ST_LINE;
                            if (r_line != '1) begin
                                n_line = r_line + LINE_WIDTH'(1);
                            end
                            n_fields = '0;
                            n_quote  = '0;
                        end
                    end
                end else if (!i_head.ws_mode) begin
                    // Separator mode: a line with any byte holds at least one field.
                    if (w_f == '0) begin
                        w_f = COUNT_WIDTH'(1);
                    end
                    if ((w_q != '0) && (i_head.data_byte == w_q)) begin
                        w_q = '0;
                    end else if (i_head.is_quote) begin
                        w_q = i_head.data_byte;
                    end
                    if (i_head.is_sep && (w_q == '0) && (w_f != '1)) begin
                        w_f = w_f + COUNT_WIDTH'(1);
                    end
                    n_fields = w_f;
                    n_quote  = w_q;
                end else begin
                    case (w_eff)
                        PH_WSQUOTE: begin
                            if (i_head.data_byte == r_quote) begin
                                n_quote = '0;
                                n_phase = PH_LINE;
                            end
                        end
                        PH_TOKEN: begin
                            if (i_head.is_space) begin
                                n_phase = PH_LINE;
                            end
                        end
                        default: begin
                            if (!i_head.is_space) begin
                                if (r_fields != '1) begin
                                    n_fields = r_fields + COUNT_WIDTH'(1);
                                end
                                if (i_head.is_quote) begin
                                    n_quote = i_head.data_byte;
                                    n_phase = PH_WSQUOTE;
                                end else begin
                                    n_phase = PH_TOKEN;
                                end
                            end
                        end
                    endcase
                end
            end
        end

        if (i_skip_load) begin
            n_to_skip = i_skip_value;
        end

        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        if (w_emit) begin
            n_out_valid       = 1'b1;
            n_out.field_count = FIELD_COUNT_W'(w_count);
            n_out.line_index  = LINE_INDEX_W'(r_line);
            n_out.status      = w_status;
            n_out.last        = w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SKIP;
            r_fields    <= '0;
            r_quote     <= '0;
            r_to_skip   <= '0;
            r_line      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_fields    <= n_fields;
            r_quote     <= n_quote;
            r_to_skip   <= n_to_skip;
            r_line      <= n_line;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the text line field counter.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tlfc_pkg::*;

    // Byte values that the stimulus uses by name.
    localparam logic [BYTE_W-1:0] CHAR_DQUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CHAR_SQUOTE = 8'h27;
    localparam logic [BYTE_W-1:0] CHAR_COMMA  = 8'h2C;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_W = 8'h77;

    // Phase boundaries are made only once this many requests are queued.
    localparam int unsigned ITEMS_PER_PHASE = 75;
    localparam int unsigned RANDOM_PHASES   = 8;

    // Full behavioral state of the counter, configuration included.
    typedef struct packed {
        logic [BYTE_W-1:0]        separator;
        logic [BYTE_W-1:0]        quote_a;
        logic [BYTE_W-1:0]        quote_b;
        logic                     skip_blank;
        logic [CFG_DATA_W-1:0]    skip_lines;
        t_phase                   phase;
        logic [FIELD_COUNT_W-1:0] fields;
        logic [BYTE_W-1:0]        open_quote;
        logic [CFG_DATA_W-1:0]    to_skip;
        logic [LINE_INDEX_W-1:0]  line_no;
    } t_line_state;

    // One queued input request and the idle cycles that follow it.
    typedef struct packed {
        t_in_item          item;
        logic [7:0]        gap_after;
    } t_byte_req;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]    i_cfg_data = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    t_in_item                 i_in_data = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    t_out_item                o_out_data;

    text_line_field_counter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // line_track follows the requests that the block has accepted and gives
    // the expected line counts. line_scout runs ahead over every request as it
    // is queued, so that the stimulus can steer clear of an early end.
    t_line_state   line_track;
    t_line_state   line_scout;
    t_byte_req     byte_queue[$];
    t_out_item     expected_counts[$];
    int unsigned   bytes_pushed = 0;
    int unsigned   bytes_taken = 0;
    int unsigned   error_count = 0;
    logic [7:0]    gap_left = '0;
    logic [7:0]    stall_left = '0;
    bit            quiet = 1'b0;
    t_out_item     predicted;
    t_byte_req     next_req;

    function automatic logic [7:0] rand_byte(input int unsigned lo, input int unsigned hi);
        logic [7:0] v;
        v = 8'($urandom_range(hi, lo));
        return v;
    endfunction

    // Idle length for either side: mostly none or short, now and then long.
    function automatic logic [7:0] pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return '0;
        if (r < 92)
            return rand_byte(1, 3);
        return rand_byte(8, 40);
    endfunction

    function automatic t_line_state fresh_state();
        t_line_state s;
        s = '0;
        s.quote_a    = CHAR_DQUOTE;
        s.quote_b    = CHAR_SQUOTE;
        s.skip_blank = 1'b1;
        s.phase      = PH_SKIP;
        return s;
    endfunction

    function automatic void set_reg(inout t_line_state s, input t_cfg_index idx,
                                     input logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_SEPARATOR:  s.separator = value[BYTE_W-1:0];
            CFG_QUOTE_A:    s.quote_a = value[BYTE_W-1:0];
            CFG_QUOTE_B:    s.quote_b = value[BYTE_W-1:0];
            CFG_SKIP_BLANK: s.skip_blank = value[0];
            CFG_SKIP_LINES: begin
                // Writing the skip count also reloads the live counter.
                s.skip_lines = value;
                s.to_skip = value;
            end
            default: ;
        endcase
    endfunction

    function automatic bit is_blank(input logic [BYTE_W-1:0] c);
        return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic bit is_quote(input t_line_state s, input logic [BYTE_W-1:0] c);
        return c != '0 && (c == s.quote_a || c == s.quote_b);
    endfunction

    function automatic void bump_fields(inout t_line_state s);
        if (s.fields != '1)
            s.fields++;
    endfunction

    // Advances the counter by one request; returns 1 when a line count comes out.
    function automatic bit count_step(inout t_line_state s, input t_in_item it,
                                      output t_out_item res);
        logic [BYTE_W-1:0] c;
        bit                ws;
        c = it.data_byte;
        ws = (s.separator == '0);
        res = '0;
        res.line_index = s.line_no;
        if (s.phase == PH_DONE)
            return 1'b0;
        if (s.phase == PH_SKIP) begin
            if (it.end_of_input) begin
                s.phase = PH_DONE;
                res.status = ST_EMPTY_END;
                res.last = 1'b1;
                return 1'b1;
            end
            if (s.to_skip != '0) begin
                if (c == CHAR_NEWLINE)
                    s.to_skip--;
                if (s.to_skip == '0)
                    s.phase = PH_LINE;
                return 1'b0;
            end
            s.phase = PH_LINE;
        end
        if (it.end_of_input) begin
            res.last = 1'b1;
            if (ws && s.phase == PH_WSQUOTE) begin
                res.status = ST_QUOTE_ERR;
            end else if (s.fields != '0) begin
                res.status = ST_FINAL;
                res.field_count = s.fields;
            end else begin
                res.status = ST_EMPTY_END;
            end
            s.phase = PH_DONE;
            return 1'b1;
        end
        if (c == CHAR_NEWLINE) begin
            if (ws && s.phase == PH_WSQUOTE) begin
                s.phase = PH_DONE;
                res.status = ST_QUOTE_ERR;
                res.last = 1'b1;
                return 1'b1;
            end
            s.phase = PH_LINE;
            if (s.fields != '0 || !s.skip_blank) begin
                res.status = ST_LINE;
                res.field_count = s.fields;
                if (s.line_no != '1)
                    s.line_no++;
                s.fields = '0;
                s.open_quote = '0;
                return 1'b1;
            end
            return 1'b0;
        end
        if (!ws) begin
            // Any byte opens the first field; separators outside quotes add more.
            if (s.fields == '0)
                bump_fields(s);
            if (s.open_quote != '0 && c == s.open_quote)
                s.open_quote = '0;
            else if (is_quote(s, c))
                s.open_quote = c;
            if (c == s.separator && s.open_quote == '0)
                bump_fields(s);
            return 1'b0;
        end
        if (s.phase == PH_WSQUOTE) begin
            if (c == s.open_quote) begin
                s.open_quote = '0;
                s.phase = PH_LINE;
            end
        end else if (s.phase == PH_TOKEN) begin
            if (is_blank(c))
                s.phase = PH_LINE;
        end else if (!is_blank(c)) begin
            bump_fields(s);
            if (is_quote(s, c)) begin
                s.open_quote = c;
                s.phase = PH_WSQUOTE;
            end else begin
                s.phase = PH_TOKEN;
            end
        end
        return 1'b0;
    endfunction

    task automatic flag_error(input string msg);
        $display("tb: %s", msg);
        error_count++;
    endtask

    // Compares one returned line count against the oldest prediction.
    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (expected_counts.size() == 0) begin
            flag_error($sformatf("stray result: count %0d line %0d status %0d last %0d",
                                 got.field_count, got.line_index, got.status, got.last));
            return;
        end
        want = expected_counts.pop_front();
        if (got.field_count !== want.field_count)
            flag_error($sformatf("line %0d: field_count %0d, wanted %0d",
                                 want.line_index, got.field_count, want.field_count));
        if (got.line_index !== want.line_index)
            flag_error($sformatf("line_index %0d, wanted %0d",
                                 got.line_index, want.line_index));
        if (got.status !== want.status)
            flag_error($sformatf("line %0d: status %0d, wanted %0d",
                                 want.line_index, got.status, want.status));
        if (got.last !== want.last)
            flag_error($sformatf("line %0d: last %0d, wanted %0d",
                                 want.line_index, got.last, want.last));
    endtask

    // Queues one request; the scout state moves on with it.
    task automatic push_item(input logic [BYTE_W-1:0] b, input bit eoi);
        t_byte_req  req;
        t_out_item  unused;
        req.item.data_byte = b;
        req.item.end_of_input = eoi;
        req.gap_after = pick_gap();
        void'(count_step(line_scout, req.item, unused));
        byte_queue.push_back(req);
        bytes_pushed++;
    endtask

    task automatic push_byte(input logic [BYTE_W-1:0] b);
        push_item(b, 1'b0);
    endtask

    task automatic push_text(input string text);
        int i;
        for (i = 0; i < text.len(); i++)
            push_byte(text[i]);
    endtask

    // A newline inside an open whitespace-mode quote would end the stream
    // with an error, so the quote is closed first; only the final request
    // of the run may end it.
    task automatic push_safe(input logic [BYTE_W-1:0] b);
        if (b == CHAR_NEWLINE && line_scout.separator == '0 && line_scout.phase == PH_WSQUOTE)
            push_byte(line_scout.open_quote);
        push_byte(b);
    endtask

    function automatic logic [BYTE_W-1:0] word_byte();
        if ($urandom_range(0, 9) == 0)
            return rand_byte(0, 255);
        return rand_byte(33, 126);
    endfunction

    // One line of random tokens: plain words, quoted stretches (a few left
    // open), separators, blanks and raw noise bytes.
    task automatic push_random_line();
        int unsigned      tokens;
        logic [BYTE_W-1:0] q;
        logic [BYTE_W-1:0] b;
        if ($urandom_range(0, 19) == 0)
            tokens = $urandom_range(9, 30);
        else
            tokens = $urandom_range(0, 6);
        repeat (tokens) begin
            case ($urandom_range(0, 9)) inside
                [0:3]: begin
                    repeat ($urandom_range(1, 4))
                        push_safe(word_byte());
                end
                [4:5]: begin
                    case ($urandom_range(0, 3)) inside
                        [0:1]:   q = line_scout.quote_a;
                        2:       q = line_scout.quote_b;
                        default: q = rand_byte(0, 255);
                    endcase
                    push_safe(q);
                    repeat ($urandom_range(0, 4)) begin
                        b = word_byte();
                        if (b == q)
                            b = CHAR_LOWER_A;
                        push_safe(b);
                    end
                    if ($urandom_range(0, 7) != 0)
                        push_safe(q);
                end
                [6:7]: begin
                    if (line_scout.separator != '0)
                        push_safe(line_scout.separator);
                    else
                        push_safe(CHAR_SPACE);
                end
                8: begin
                    if ($urandom_range(0, 1) == 0)
                        push_safe(CHAR_SPACE);
                    else
                        push_safe(rand_byte(9, 13));
                end
                default: push_safe(rand_byte(0, 255));
            endcase
        end
        // Now and then the newline is left out, so two lines run together.
        if ($urandom_range(0, 9) != 0)
            push_safe(CHAR_NEWLINE);
    endtask

    // Register writes go out back to back; both predictor copies follow.
    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        set_reg(line_track, idx, value);
        set_reg(line_scout, idx, value);
    endtask

    task automatic end_writes();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Waits until every queued request is taken and every line count is back,
    // then waits on while the queue drains requests that give no result.
    task automatic wait_idle();
        while (bytes_taken != bytes_pushed || expected_counts.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic random_config();
        logic [BYTE_W-1:0]     sep;
        logic [BYTE_W-1:0]     qa;
        logic [BYTE_W-1:0]     qb;
        logic [CFG_DATA_W-1:0] skip;
        case ($urandom_range(0, 7)) inside
            [0:2]:   sep = '0;
            3:       sep = CHAR_COMMA;
            4:       sep = CHAR_TAB;
            5:       sep = CHAR_SPACE;
            6:       sep = 8'hFF;
            default: sep = rand_byte(1, 255);
        endcase
        case ($urandom_range(0, 3))
            0:       qa = '0;
            1:       qa = CHAR_DQUOTE;
            2:       qa = 8'hFF;
            default: qa = rand_byte(1, 255);
        endcase
        case ($urandom_range(0, 3))
            0:       qb = '0;
            1:       qb = CHAR_SQUOTE;
            2:       qb = 8'hFF;
            default: qb = rand_byte(1, 255);
        endcase
        case ($urandom_range(0, 2))
            0:       skip = '0;
            1:       skip = '1;
            default: skip = CFG_DATA_W'($urandom_range(0, 65535));
        endcase
        write_reg(CFG_SEPARATOR, {8'h00, sep});
        write_reg(CFG_QUOTE_A, {8'h00, qa});
        write_reg(CFG_QUOTE_B, {8'h00, qb});
        write_reg(CFG_SKIP_BLANK, CFG_DATA_W'($urandom_range(0, 1)));
        // The skip phase is long over, so this only reloads the idle counter.
        write_reg(CFG_SKIP_LINES, skip);
        end_writes();
    endtask

    // Request driver: presents queued bytes, holding each until accepted, and
    // runs the prediction for every request at the edge that accepts it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                bytes_taken++;
                if (count_step(line_track, i_in_data, predicted))
                    expected_counts.push_back(predicted);
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left != '0) begin
                    gap_left = gap_left - 1'b1;
                    i_in_valid <= 1'b0;
                end else if (byte_queue.size() != 0) begin
                    next_req = byte_queue.pop_front();
                    gap_left = next_req.gap_after;
                    i_in_data <= next_req.item;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks every accepted line count and stalls the output
    // channel at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready)
                check_result(o_out_data);
            if (stall_left != '0) begin
                stall_left = stall_left - 1'b1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if ($urandom_range(0, 99) < 25)
                    stall_left = pick_gap();
            end
        end
    end

    // Stimulus: a directed opening, random phases under changing settings,
    // and a single end of stream followed by ignored requests.
    initial begin
        int unsigned phase_start;
        int unsigned end_kind;
        int          p;
        line_track = fresh_state();
        line_scout = fresh_state();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Leading-line skip: the largest count is written first, then replaced
        // by two before any byte arrives.
        write_reg(CFG_SKIP_LINES, '1);
        write_reg(CFG_SKIP_LINES, 16'd2);
        end_writes();
        push_text("'\n");           // skipped, a quote in it has no effect
        push_text("\n");            // skipped, counting starts after it
        push_text("\t\"x y\"z\n");  // a quoted string and a token: two fields
        push_text("\n");            // blank line, suppressed by default
        push_byte(8'h00);           // the lowest and highest byte form one token
        push_byte(8'hFF);
        push_byte(CHAR_CR);
        push_byte(CHAR_NEWLINE);
        wait_idle();

        // Separator mode with only the double quote, blank lines reported.
        write_reg(CFG_SEPARATOR, {8'h00, CHAR_COMMA});
        write_reg(CFG_QUOTE_B, '0);
        write_reg(CFG_SKIP_BLANK, '0);
        end_writes();
        push_text(",\"a,b\",\n");   // a separator inside quotes does not count
        push_text("\n");            // blank line gives a count of zero
        push_text("\"a,\n");        // newline ends the line and the open quote
        wait_idle();

        // Random phases; some end in mid-line so the next settings take over a
        // partial line, and one runs with no idling on either side.
        for (p = 0; p < RANDOM_PHASES; p++) begin
            random_config();
            quiet = (p == 3);
            phase_start = bytes_pushed;
            while (bytes_pushed - phase_start < ITEMS_PER_PHASE)
                push_random_line();
            if ($urandom_range(0, 1) == 0)
                repeat ($urandom_range(1, 3)) push_safe(word_byte());
            wait_idle();
        end
        quiet = 1'b0;

        // The stream ends once per run: with fields pending, with nothing
        // pending, or in an open whitespace-mode quote at end or at newline.
        end_kind = $urandom_range(0, 3);
        if (end_kind >= 2 || $urandom_range(0, 1) == 0)
            write_reg(CFG_SEPARATOR, '0);
        else
            write_reg(CFG_SEPARATOR, {8'h00, CHAR_COMMA});
        write_reg(CFG_QUOTE_A, {8'h00, CHAR_DQUOTE});
        end_writes();
        push_safe(CHAR_NEWLINE);
        case (end_kind)
            0: begin
                push_byte(CHAR_LOWER_W);
                push_item(rand_byte(0, 255), 1'b1);
            end
            1: push_item(rand_byte(0, 255), 1'b1);
            2: begin
                push_byte(CHAR_DQUOTE);
                push_byte(CHAR_LOWER_A);
                push_item(rand_byte(0, 255), 1'b1);
            end
            default: begin
                push_byte(CHAR_DQUOTE);
                push_byte(CHAR_LOWER_A);
                push_byte(CHAR_NEWLINE);
            end
        endcase
        // After the last result the block must take and drop everything.
        repeat (6) push_item(rand_byte(0, 255), 1'($urandom_range(0, 1)));
        wait_idle();
        repeat (8) @(posedge i_clk);

        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    // Far beyond the slowest correct run, long gaps and stalls included.
    initial begin
        #10_000_000;
        $display("tb: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/tlfc_pkg.sv
hdl/tlfc_front.sv
hdl/tlfc_back.sv
hdl/text_line_field_counter.sv
test/tb.sv
